/* rtl/core/dvs_pkg.sv */
package dvs_pkg;

    typedef enum logic [1:0]
    {
        ST_STEPPED   = 2'd0,
        ST_CLAMPED   = 2'd1,
        ST_UNCHANGED = 2'd2,
        ST_INVALID   = 2'd3
    } step_status_t;

    typedef enum logic [1:0]
    {
        CFG_GRAVITY     = 2'd0,
        CFG_AIR_DENSITY = 2'd1,
        CFG_DRAG_COEFF  = 2'd2,
        CFG_TIME_STEP   = 2'd3
    } cfg_idx_t;

    typedef struct packed
    {
        logic signed [31:0] velocity_in;
        logic [30:0]        body_mass;
        logic [30:0]        body_area;
    } item_t;

    typedef struct packed
    {
        logic signed [31:0] velocity_out;
        logic [30:0]        terminal_speed;
        step_status_t       step_status;
    } result_t;

    // payload riding alongside the drag path
    typedef struct packed
    {
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic [30:0]        mass;
        logic [30:0]        area;
        logic               invalid;
    } step_side_t;

    typedef struct packed
    {
        logic signed [31:0] v0;
        logic signed [31:0] v2;
        logic               invalid;
    } step_res_t;

    localparam logic [30:0] GRAVITY_RST     = 31'd642253;
    localparam logic [30:0] AIR_DENSITY_RST = 31'd80282;
    localparam logic [30:0] DRAG_COEFF_RST  = 31'd65536;
    localparam logic [30:0] TIME_STEP_RST   = 31'd1049;

    localparam logic [62:0] CAP62 = 63'h4000_0000_0000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -66'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

/* rtl/core/dvs_div.sv */
module dvs_div #(
    parameter int NW = 63,
    parameter int DW = 46,
    parameter int QW = 63,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    // one quotient bit per stage; top of dividend assumed below divisor
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [DW-1:0] dsr_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic [DW-1:0] rem_prev;
        logic [DW-1:0] dsr_prev;
        logic [QW-1:0] quo_prev;
        logic [QW-1:0] low_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (j == 0)
        begin : g_first
            assign rem_prev  = DW'(dividend >> QW);
            assign dsr_prev  = divisor;
            assign quo_prev  = '0;
            assign low_prev  = dividend[QW-1:0];
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign dsr_prev  = dsr_reg[j-1];
            assign quo_prev  = quo_reg[j-1];
            assign low_prev  = low_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        assign trial = {rem_prev, low_prev[QW-1-j]};
        assign diff  = trial - {1'b0, dsr_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, dsr_prev})
                begin
                    rem_reg[j] <= diff[DW-1:0];
                    quo_reg[j] <= quo_prev | (QW'(1) << (QW-1-j));
                end
                else
                begin
                    rem_reg[j] <= trial[DW-1:0];
                    quo_reg[j] <= quo_prev;
                end
                low_reg[j]  <= low_prev;
                dsr_reg[j]  <= dsr_prev;
                side_reg[j] <= side_prev;
            end
        end
    end

    assign quotient = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

/* rtl/core/dvs_sqrt.sv */
module dvs_sqrt #(
    parameter int RW = 31,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   side_in,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    // one root bit per stage, remainder form
    logic [2*RW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [SW-1:0]   side_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int B = RW - 1 - j;
        logic [2*RW-1:0] rem_prev;
        logic [RW-1:0]   root_prev;
        logic [SW-1:0]   side_prev;
        logic [2*RW:0]   trial;
        logic [2*RW:0]   diff;

        if (j == 0)
        begin : g_first
            assign rem_prev  = radicand;
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign root_prev = root_reg[j-1];
            assign side_prev = side_reg[j-1];
        end

        assign trial = ((2*RW+1)'(root_prev) << (B + 1)) + ((2*RW+1)'(1) << (2 * B));
        assign diff  = {1'b0, rem_prev} - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial <= {1'b0, rem_prev})
                begin
                    rem_reg[j]  <= diff[2*RW-1:0];
                    root_reg[j] <= root_prev | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[j]  <= rem_prev;
                    root_reg[j] <= root_prev;
                end
                side_reg[j] <= side_prev;
            end
        end
    end

    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

/* rtl/core/dvs_mulfix.sv */
module dvs_mulfix
    import dvs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [62:0]   a,
    input  logic [30:0]   b,
    input  logic [SW-1:0] side_in,
    output logic [62:0]   product,
    output logic [SW-1:0] side_out
);

    logic [62:0]   pp_lo_reg;
    logic [61:0]   pp_hi_reg;
    logic [SW-1:0] side1_reg;
    logic [62:0]   prod_reg;
    logic [SW-1:0] side2_reg;
    logic [93:0]   full;

    // full product at or above 2^64 saturates
    assign full = {pp_hi_reg, 32'd0} + 94'(pp_lo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_lo_reg <= a[31:0] * b;
            pp_hi_reg <= a[62:32] * b;
            side1_reg <= side_in;
            prod_reg  <= (|full[93:64]) ? CAP62 : 63'(full >> FRAC_BITS);
            side2_reg <= side1_reg;
        end
    end

    assign product  = prod_reg;
    assign side_out = side2_reg;

endmodule

/* rtl/core/drag_velocity_step.sv */
// Velocity step of a falling body under gravity and quadratic drag.
// Items come in on item_valid/item_ready/item (velocity, mass, area) and
// results leave on result_valid/result_ready/result (new velocity,
// terminal speed, status). Configuration (gravity, air density, drag
// coefficient, time step) is written through cfg_write/cfg_index/cfg_data
// and should only change while no items are in flight.
// Throughput: one item per cycle while the receiver does not stall. The
// terminal-speed path is the longer one: a 63-stage divider, a 62-stage
// divider and a 31-stage square root, one bit per stage. The drag path
// runs alongside and is delayed to meet it.
// Reset clears all valid bits, including the output valid, and restores
// default configuration. When the receiver stalls, the whole pipeline holds
// and item_ready drops; nothing is lost or repeated.
module drag_velocity_step
    import dvs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  cfg_idx_t    cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    localparam int DIV1_QW  = 63;
    localparam int DIV2_QW  = 62;
    localparam int DIV3_QW  = 63;
    localparam int ROOT_W   = 31;
    localparam int MUL_LAT  = 2;
    localparam int TERM_LAT = 1 + DIV1_QW + 1 + DIV2_QW + ROOT_W;
    localparam int STEP_PRE = 3 + 3 * MUL_LAT + 1 + DIV3_QW + MUL_LAT;
    localparam int TAIL     = TERM_LAT - STEP_PRE;
    localparam int DEN_W    = 62 - FRAC_BITS;
    localparam int SIDE_W   = $bits(step_side_t);

    logic [30:0] gravity_reg;
    logic [30:0] air_density_reg;
    logic [30:0] drag_coeff_reg;
    logic [30:0] time_step_reg;

    logic                adv;
    logic [TERM_LAT-1:0] valid_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg     <= GRAVITY_RST;
            air_density_reg <= AIR_DENSITY_RST;
            drag_coeff_reg  <= DRAG_COEFF_RST;
            time_step_reg   <= TIME_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GRAVITY:     gravity_reg     <= cfg_data;
                CFG_AIR_DENSITY: air_density_reg <= cfg_data;
                CFG_DRAG_COEFF:  drag_coeff_reg  <= cfg_data;
                CFG_TIME_STEP:   time_step_reg   <= cfg_data;
                default:         gravity_reg     <= gravity_reg;
            endcase
        end
    end

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[TERM_LAT-2:0], item_valid};
    end

    // ---------------- terminal speed path ----------------
    logic [62:0] num_reg;
    logic [61:0] rc_reg;
    logic [30:0] t1_area_reg;

    logic [DEN_W-1:0] den;
    logic [62:0]      k_q;
    logic [31:0]      d1_side_out;

    logic [62:0] k_reg;
    logic [30:0] t3_area_reg;
    logic        ovf2_reg;
    logic        t3_dz_reg;

    logic [61:0] q2;
    logic [1:0]  d2_side_out;
    logic [61:0] radicand;
    logic [30:0] root;
    logic        dz_out;

    assign den = rc_reg[61:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg     <= {62'(gravity_reg) * 62'(item.body_mass), 1'b0};
            rc_reg      <= air_density_reg * drag_coeff_reg;
            t1_area_reg <= item.body_area;
        end
    end

    dvs_div #(
        .NW(63),
        .DW(DEN_W),
        .QW(DIV1_QW),
        .SW(32)
    ) u_div_k (
        .clk     (clk),
        .en      (adv),
        .dividend(num_reg),
        .divisor (den),
        .side_in ({t1_area_reg, (den == '0)}),
        .quotient(k_q),
        .side_out(d1_side_out)
    );

    // k * 2^2F / A overflows 62 bits exactly when k >> (62-2F) >= A
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg       <= k_q;
            t3_area_reg <= d1_side_out[31:1];
            ovf2_reg    <= (k_q >> (62 - 2 * FRAC_BITS)) >= 63'(d1_side_out[31:1]);
            t3_dz_reg   <= d1_side_out[0];
        end
    end

    dvs_div #(
        .NW(63 + 2 * FRAC_BITS),
        .DW(31),
        .QW(DIV2_QW),
        .SW(2)
    ) u_div_s (
        .clk     (clk),
        .en      (adv),
        .dividend({k_reg, (2 * FRAC_BITS)'(0)}),
        .divisor (t3_area_reg),
        .side_in ({ovf2_reg, t3_dz_reg}),
        .quotient(q2),
        .side_out(d2_side_out)
    );

    assign radicand = d2_side_out[1] ? '1 : q2;

    dvs_sqrt #(
        .RW(ROOT_W),
        .SW(1)
    ) u_sqrt (
        .clk     (clk),
        .en      (adv),
        .radicand(radicand),
        .side_in (d2_side_out[0]),
        .root    (root),
        .side_out(dz_out)
    );

    // ---------------- drag step path ----------------
    item_t              s1_item_reg;
    logic               s1_inv_reg;
    logic [61:0]        gdp_reg;
    item_t              s2_item_reg;
    logic               s2_inv_reg;
    logic signed [31:0] v1_reg;
    logic [31:0]        mag;
    logic [62:0]        sq_reg;
    step_side_t         s3_side_reg;

    logic [62:0]       p1;
    logic [62:0]       p2;
    logic [62:0]       p3;
    logic [SIDE_W-1:0] m1_side;
    logic [SIDE_W-1:0] m2_side;
    logic [SIDE_W-1:0] m3_side;
    step_side_t        m3_side_s;

    logic [62:0]       p_reg;
    logic              ovf3_reg;
    step_side_t        s4_side_reg;
    logic [62:0]       q3;
    logic [SIDE_W:0]   d3_side_out;
    logic [62:0]       acc;
    logic [62:0]       dv;
    logic [SIDE_W-1:0] m4_side;
    step_side_t        m4_side_s;
    logic signed [65:0] diff2;
    step_res_t         tail_reg [TAIL];

    assign mag  = v1_reg[31] ? (~v1_reg + 32'd1) : v1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= item;
            s1_inv_reg  <= (item.body_mass == '0) || (item.body_area == '0);
            gdp_reg     <= gravity_reg * time_step_reg;

            s2_item_reg <= s1_item_reg;
            s2_inv_reg  <= s1_inv_reg;
            v1_reg      <= sat32($signed({{34{s1_item_reg.velocity_in[31]}},
                                          s1_item_reg.velocity_in})
                                 + $signed(66'(gdp_reg >> FRAC_BITS)));

            sq_reg              <= 63'(mag) * 63'(mag);
            s3_side_reg.v0      <= s2_item_reg.velocity_in;
            s3_side_reg.v1      <= v1_reg;
            s3_side_reg.mass    <= s2_item_reg.body_mass;
            s3_side_reg.area    <= s2_item_reg.body_area;
            s3_side_reg.invalid <= s2_inv_reg;
        end
    end

    dvs_mulfix #(
        .FRAC_BITS(FRAC_BITS),
        .SW       (SIDE_W)
    ) u_mul_rho (
        .clk     (clk),
        .en      (adv),
        .a       (sq_reg >> FRAC_BITS),
        .b       (air_density_reg),
        .side_in (s3_side_reg),
        .product (p1),
        .side_out(m1_side)
    );

    dvs_mulfix #(
        .FRAC_BITS(FRAC_BITS),
        .SW       (SIDE_W)
    ) u_mul_cd (
        .clk     (clk),
        .en      (adv),
        .a       (p1),
        .b       (drag_coeff_reg),
        .side_in (m1_side),
        .product (p2),
        .side_out(m2_side)
    );

    step_side_t m2_side_s;
    assign m2_side_s = m2_side;

    dvs_mulfix #(
        .FRAC_BITS(FRAC_BITS),
        .SW       (SIDE_W)
    ) u_mul_area (
        .clk     (clk),
        .en      (adv),
        .a       (p2),
        .b       (m2_side_s.area),
        .side_in (m2_side),
        .product (p3),
        .side_out(m3_side)
    );

    assign m3_side_s = m3_side;

    // p * 2^F / m overflows 63 bits exactly when p >> (63-F) >= m
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg       <= p3 >> 1;
            ovf3_reg    <= ((p3 >> 1) >> (63 - FRAC_BITS)) >= 63'(m3_side_s.mass);
            s4_side_reg <= m3_side_s;
        end
    end

    dvs_div #(
        .NW(63 + FRAC_BITS),
        .DW(31),
        .QW(DIV3_QW),
        .SW(SIDE_W + 1)
    ) u_div_acc (
        .clk     (clk),
        .en      (adv),
        .dividend({p_reg, FRAC_BITS'(0)}),
        .divisor (s4_side_reg.mass),
        .side_in ({ovf3_reg, s4_side_reg}),
        .quotient(q3),
        .side_out(d3_side_out)
    );

    assign acc = (d3_side_out[SIDE_W] || (q3 > CAP62)) ? CAP62 : q3;

    dvs_mulfix #(
        .FRAC_BITS(FRAC_BITS),
        .SW       (SIDE_W)
    ) u_mul_dt (
        .clk     (clk),
        .en      (adv),
        .a       (acc),
        .b       (time_step_reg),
        .side_in (d3_side_out[SIDE_W-1:0]),
        .product (dv),
        .side_out(m4_side)
    );

    assign m4_side_s = m4_side;
    assign diff2     = $signed({{34{m4_side_s.v1[31]}}, m4_side_s.v1})
                     - $signed({3'b000, dv});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg[0].v0      <= m4_side_s.v0;
            tail_reg[0].v2      <= sat32(diff2);
            tail_reg[0].invalid <= m4_side_s.invalid;
            for (int i = 1; i < TAIL; i++)
                tail_reg[i] <= tail_reg[i-1];
        end
    end

    // ---------------- merge and output register ----------------
    step_res_t   fin;
    logic [30:0] t_fin;
    result_t     res_next;

    assign fin   = tail_reg[TAIL-1];
    assign t_fin = dz_out ? '1 : root;

    always_comb
    begin
        res_next.velocity_out   = fin.v0;
        res_next.terminal_speed = t_fin;
        res_next.step_status    = ST_STEPPED;
        if (fin.invalid)
        begin
            res_next.terminal_speed = '0;
            res_next.step_status    = ST_INVALID;
        end
        else if (fin.v0 >= $signed({1'b0, t_fin}))
        begin
            res_next.step_status = ST_UNCHANGED;
        end
        else if (fin.v2 > $signed({1'b0, t_fin}))
        begin
            res_next.velocity_out = $signed({1'b0, t_fin});
            res_next.step_status  = ST_CLAMPED;
        end
        else
        begin
            res_next.velocity_out = fin.v2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= valid_reg[TERM_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= res_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_invalid_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.step_status == ST_INVALID) |-> result.terminal_speed == '0)
        else $error("invalid item with nonzero terminal speed");

    a_clamp_at_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.step_status == ST_CLAMPED)
        |-> result.velocity_out == $signed({1'b0, result.terminal_speed}))
        else $error("clamped velocity differs from terminal speed");

    a_step_below_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.step_status == ST_STEPPED)
        |-> result.velocity_out <= $signed({1'b0, result.terminal_speed}))
        else $error("stepped velocity above terminal speed");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> valid_reg[0])
        else $error("accepted item lost at pipeline entry");

endmodule

/* tb/tb_drag_velocity_step.sv */
`timescale 1ns / 100ps

module tb_drag_velocity_step;
    import dvs_pkg::*;

    localparam int FB = 16;
    localparam longint unsigned CAP = 64'h4000_0000_0000_0000;
    localparam longint unsigned MAX31 = 64'h7FFF_FFFF;

    class step_scoreboard;
        longint unsigned grav, rho, cd, dt;
        result_t expected_q[$];
        int errors;

        function new();
            grav = GRAVITY_RST;
            rho = AIR_DENSITY_RST;
            cd = DRAG_COEFF_RST;
            dt = TIME_STEP_RST;
            errors = 0;
        endfunction

        function longint unsigned mul_frac(longint unsigned a, longint unsigned b);
            longint unsigned p;
            if (a == 0 || b == 0)
                return 0;
            if (a > 64'hFFFF_FFFF_FFFF_FFFF / b)
                return CAP;
            p = (a * b) >> FB;
            return (p > CAP) ? CAP : p;
        endfunction

        function longint unsigned div_scaled(longint unsigned x, int s, longint unsigned y,
                                            longint unsigned lim);
            longint unsigned q, r;
            q = x / y;
            r = x % y;
            if (q > lim)
                return lim;
            for (int i = 0; i < s; i++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= y)
                begin
                    r = r - y;
                    q = q | 1;
                end
                if (q > lim)
                    return lim;
            end
            return q;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= res + b)
                begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint sat_s32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned terminal(longint unsigned m, longint unsigned a);
            longint unsigned den, k, s, t;
            den = (rho * cd) >> FB;
            if (den == 0)
                return MAX31;
            k = (2 * grav * m) / den;
            s = div_scaled(k, 2 * FB, a, CAP - 1);
            t = root_floor(s);
            return (t > MAX31) ? MAX31 : t;
        endfunction

        function result_t next_velocity(item_t it);
            result_t r;
            longint unsigned m, a, t, mag, p, acc, dv;
            longint v, v1, v2;
            m = it.body_mass;
            a = it.body_area;
            v = it.velocity_in;
            if (m == 0 || a == 0)
            begin
                r.velocity_out = it.velocity_in;
                r.terminal_speed = '0;
                r.step_status = ST_INVALID;
                return r;
            end
            t = terminal(m, a);
            r.terminal_speed = t[30:0];
            if (v >= longint'(t))
            begin
                r.velocity_out = it.velocity_in;
                r.step_status = ST_UNCHANGED;
                return r;
            end
            v1 = sat_s32(v + longint'((grav * dt) >> FB));
            mag = (v1 < 0) ? longint'(-v1) : longint'(v1);
            p = (mag * mag) >> FB;
            p = mul_frac(p, rho);
            p = mul_frac(p, cd);
            p = mul_frac(p, a);
            p = p >> 1;
            acc = div_scaled(p, FB, m, CAP);
            dv = mul_frac(acc, dt);
            v2 = sat_s32(v1 - longint'(dv));
            r.step_status = ST_STEPPED;
            if (v2 > longint'(t))
            begin
                v2 = longint'(t);
                r.step_status = ST_CLAMPED;
            end
            r.velocity_out = v2[31:0];
            return r;
        endfunction

        function void note_item(item_t it);
            expected_q = {expected_q, next_velocity(it)};
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.velocity_out !== exp_r.velocity_out)
            begin
                $error("velocity_out: expected %0d, got %0d", exp_r.velocity_out,
                       got.velocity_out);
                errors++;
            end
            if (got.terminal_speed !== exp_r.terminal_speed)
            begin
                $error("terminal_speed: expected %0d, got %0d", exp_r.terminal_speed,
                       got.terminal_speed);
                errors++;
            end
            if (got.step_status !== exp_r.step_status)
            begin
                $error("step_status: expected %0d, got %0d", exp_r.step_status,
                       got.step_status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    cfg_idx_t    cfg_index;
    logic [30:0] cfg_data;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;

    step_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_cycles;

    drag_velocity_step dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #5ms;
        $display("drag_velocity_step test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_item(item);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_item(item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic write_config(longint unsigned g, longint unsigned r, longint unsigned c,
                                longint unsigned d);
        logic [30:0] vals[4];
        vals[0] = g[30:0];
        vals[1] = r[30:0];
        vals[2] = c[30:0];
        vals[3] = d[30:0];
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        sb.grav = vals[0];
        sb.rho = vals[1];
        sb.cd = vals[2];
        sb.dt = vals[3];
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [30:0] rand_mag();
        if ($urandom_range(19) == 0)
            return '0;
        return 31'($urandom() >> $urandom_range(1, 31));
    endfunction

    function automatic item_t rand_item();
        item_t it;
        longint t, v;
        it.body_mass = rand_mag();
        it.body_area = rand_mag();
        case ($urandom_range(3))
            0: it.velocity_in = $urandom();
            1: it.velocity_in = $signed($urandom_range(0, 1 << 20)) *
                                ($urandom_range(1) ? 1 : -1);
            default:
            begin
                if (it.body_mass != 0 && it.body_area != 0)
                    t = longint'(sb.terminal(it.body_mass, it.body_area));
                else
                    t = 0;
                v = sb.sat_s32(t + longint'($urandom_range(0, 8192)) - 4096);
                it.velocity_in = v[31:0];
            end
        endcase
        return it;
    endfunction

    task automatic directed_items();
        item_t it;
        logic [30:0] ms[5] = '{31'd0, 31'd1, 31'd65536, 31'h7FFF_FFFF, 31'd200000};
        logic [31:0] vs[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_0000,
                               32'd1000000};
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j += 2)
            begin
                it.velocity_in = vs[(i + j) % 5];
                it.body_mass = ms[i];
                it.body_area = ms[(i + j + 1) % 5];
                push_item(it);
            end
        it.body_mass = 31'd65536;
        it.body_area = 31'd6554;
        it.velocity_in = 32'(sb.terminal(it.body_mass, it.body_area)) - 32'd10;
        push_item(it);
    endtask

    initial
    begin
        longint unsigned cfgs[7][4];
        int modes[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{26, 26}};
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_GRAVITY;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        cfgs[0] = '{GRAVITY_RST, AIR_DENSITY_RST, DRAG_COEFF_RST, TIME_STEP_RST};
        cfgs[1] = '{0, AIR_DENSITY_RST, DRAG_COEFF_RST, TIME_STEP_RST};
        cfgs[2] = '{MAX31, 1, 1, MAX31};
        cfgs[3] = '{MAX31, MAX31, MAX31, 0};
        cfgs[4] = '{642253, 1, 65536, 1049};
        cfgs[5] = '{64'd1 << 20, 64'd1 << 24, 64'd1 << 14, 64'd1 << 18};
        cfgs[6] = '{$urandom() >> 1, $urandom() >> 8, $urandom() >> 8, $urandom() >> 12};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        drain();
        for (int ph = 0; ph < 7; ph++)
        begin
            write_config(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3]);
            if (ph == 1 || ph == 2 || ph == 4)
            begin
                idle_pct = 0;
                stall_pct = 0;
                for (int i = 0; i < 4; i++)
                    push_item(rand_item());
                drain();
            end
            for (int sub = 0; sub < 4; sub++)
            begin
                idle_pct = modes[sub][0];
                stall_pct = modes[sub][1];
                if (ph == 0 && sub == 0)
                    hold_cycles = 400;
                for (int i = 0; i < 64; i++)
                    push_item(rand_item());
            end
            drain();
        end

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("drag_velocity_step test passed");
        else
            $display("drag_velocity_step test failed");
        $finish;
    end

endmodule
